// ----- src/mtd_pkg.sv -----
// ----------------------------------------------------------------------------
// mtd_pkg
// Types and constants shared by the MFM track deframer and checksum unit.
// ----------------------------------------------------------------------------
package mtd_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_SYNC_PATTERN = 4'd0;
  localparam logic [3:0] CFG_PAD_LONG     = 4'd1;
  localparam logic [3:0] CFG_PAD_SHORT    = 4'd2;
  localparam logic [3:0] CFG_BLOCK_WORDS  = 4'd3;

  // Register reset values
  localparam logic [15:0] SyncPatternRst = 16'h4489;
  localparam logic [31:0] PadLongRst     = 32'h5555_5149;
  localparam logic [15:0] PadShortRst    = 16'h452A;
  localparam logic [11:0] BlockWordsRst  = 12'd1538;

  localparam int SyncOffsetW = 20;
  localparam int ByteIndexW  = 13;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_PADL = 5'b00010,
    PH_PADS = 5'b00100,
    PH_ODD  = 5'b01000,
    PH_EVEN = 5'b10000
  } phase_e;

  typedef struct packed {
    logic raw_bit;
    logic index_mark;
  } in_item_t;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [ByteIndexW-1:0]  byte_index;
    logic                   last_byte;
    logic                   checksum_ok;
    logic [SyncOffsetW-1:0] sync_offset;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  reg_index;
    logic [31:0] wdata;
  } cfg_req_t;

  // Framer to checksum control
  typedef struct packed {
    logic       clear;
    logic       byte_en;
    logic       add_word;
    logic       check_word;
    logic [7:0] data_byte;
  } ck_ctrl_t;

endpackage

// ----- src/mtd_stream_if.sv -----
// ----------------------------------------------------------------------------
// mtd_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface mtd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/mtd_ram.sv -----
// ----------------------------------------------------------------------------
// mtd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtd_ram #(
  parameter int Width = 4,
  parameter int Depth = 8192,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mtd_checksum.sv -----
// ----------------------------------------------------------------------------
// mtd_checksum
// Big-endian word assembly, wrapping block sum and checksum compare.
// ----------------------------------------------------------------------------
module mtd_checksum
  import mtd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ck_ctrl_t ctrl_i,
  output logic     sum_match_o
);

  logic [31:0] word_q, word_d, word_new;
  logic [31:0] sum_q, sum_d;
  logic        match_q, match_d;

  always_comb begin
    word_new = {word_q[23:0], ctrl_i.data_byte};
    word_d   = word_q;
    sum_d    = sum_q;
    match_d  = match_q;
    if (ctrl_i.clear) begin
      word_d  = '0;
      sum_d   = '0;
      match_d = 1'b0;
    end else if (ctrl_i.byte_en) begin
      word_d = word_new;
      if (ctrl_i.add_word) begin
        sum_d = sum_q + word_new;
      end
      if (ctrl_i.check_word) begin
        match_d = (sum_q == word_new);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      sum_q   <= '0;
      match_q <= 1'b0;
    end else begin
      word_q  <= word_d;
      sum_q   <= sum_d;
      match_q <= match_d;
    end
  end

  assign sum_match_o = match_q;

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (sum_q == 32'd0) && !match_q)
    else $error("checksum state not cleared at block start");

endmodule

// ----- src/mtd_framer.sv -----
// ----------------------------------------------------------------------------
// mtd_framer
// Sync hunt, padding check, odd/even half sequencing and byte decode.
// ----------------------------------------------------------------------------
module mtd_framer
  import mtd_pkg::*;
#(
  parameter int MaxBlockBytes = 8192,
  parameter int PositionBits  = 20,
  localparam int AddrW = $clog2(MaxBlockBytes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  in_item_t         in_item_i,
  input  logic [15:0]      cfg_sync_i,
  input  logic [31:0]      cfg_pad_long_i,
  input  logic [15:0]      cfg_pad_short_i,
  input  logic [11:0]      cfg_words_i,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_addr_o,
  output logic [3:0]       ram_wdata_o,
  input  logic [3:0]       ram_rdata_i,
  output ck_ctrl_t         ck_ctrl_o,
  input  logic             sum_match_i,
  output logic             emit_pending_o,
  output logic             emit_o,
  output out_item_t        item_o
);

  localparam int CountW   = $clog2(MaxBlockBytes + 1);
  localparam int MaxWords = MaxBlockBytes / 4;
  localparam int WordsW   = $clog2(MaxWords + 1);

  phase_e                  phase_q, phase_d;
  logic [31:0]             shift_q, shift_d, shift_new;
  logic [4:0]              bit_count_q, bit_count_d, bc_inc;
  logic [CountW-1:0]       byte_count_q, byte_count_d;
  logic [PositionBits-1:0] bit_pos_q, bit_pos_d, pos;
  logic [PositionBits-1:0] sync_pos_q, sync_pos_d;
  logic [WordsW-1:0]       words_q, words_d, words_clamp;
  logic [31:0]             bw32, idx32, bytes32, sync32, word_idx32, words32;
  logic [7:0]              b, dbyte;
  logic                    last;

  // Clamp the configured length into the supported range
  always_comb begin
    bw32 = 32'(cfg_words_i);
    if (bw32 < 32'd3) begin
      words_clamp = WordsW'(3);
    end else if (bw32 > 32'(MaxWords)) begin
      words_clamp = WordsW'(MaxWords);
    end else begin
      words_clamp = WordsW'(bw32);
    end
  end

  assign idx32      = 32'(byte_count_q);
  assign words32    = 32'(words_q);
  assign bytes32    = words32 << 2;
  assign word_idx32 = idx32 >> 2;
  assign sync32     = 32'(sync_pos_q);
  assign shift_new  = {shift_q[30:0], in_item_i.raw_bit};
  assign b          = shift_new[7:0];
  assign dbyte      = {ram_rdata_i[3], b[6], ram_rdata_i[2], b[4],
                       ram_rdata_i[1], b[2], ram_rdata_i[0], b[0]};
  assign last       = (idx32 + 32'd1) >= bytes32;

  always_comb begin
    pos          = in_item_i.index_mark ? '0 : bit_pos_q;
    bc_inc       = bit_count_q + 5'd1;
    phase_d      = phase_q;
    shift_d      = shift_q;
    bit_count_d  = bit_count_q;
    byte_count_d = byte_count_q;
    bit_pos_d    = bit_pos_q;
    sync_pos_d   = sync_pos_q;
    words_d      = words_q;
    ram_we_o     = 1'b0;
    emit_o       = 1'b0;
    ck_ctrl_o    = '{clear: 1'b0, byte_en: 1'b0, add_word: 1'b0, check_word: 1'b0,
                     data_byte: dbyte};
    if (in_fire_i) begin
      bit_pos_d = pos + PositionBits'(1);
      shift_d   = shift_new;
      case (phase_q)
        PH_HUNT: begin
          if (shift_new[15:0] == cfg_sync_i) begin
            sync_pos_d  = pos - PositionBits'(15);
            words_d     = words_clamp;
            phase_d     = PH_PADL;
            bit_count_d = '0;
          end
        end
        PH_PADL: begin
          bit_count_d = bc_inc;
          if (bc_inc == 5'd0) begin
            phase_d = (shift_new == cfg_pad_long_i) ? PH_PADS : PH_HUNT;
          end
        end
        PH_PADS: begin
          bit_count_d = bc_inc;
          if (bc_inc == 5'd16) begin
            bit_count_d  = '0;
            byte_count_d = '0;
            if (shift_new[15:0] == cfg_pad_short_i) begin
              phase_d         = PH_ODD;
              ck_ctrl_o.clear = 1'b1;
            end else begin
              phase_d = PH_HUNT;
            end
          end
        end
        PH_ODD: begin
          bit_count_d = bc_inc;
          if (bc_inc == 5'd8) begin
            bit_count_d  = '0;
            ram_we_o     = 1'b1;
            byte_count_d = byte_count_q + CountW'(1);
            if (last) begin
              byte_count_d = '0;
              phase_d      = PH_EVEN;
            end
          end
        end
        PH_EVEN: begin
          bit_count_d = bc_inc;
          if (bc_inc == 5'd8) begin
            bit_count_d          = '0;
            emit_o               = 1'b1;
            ck_ctrl_o.byte_en    = 1'b1;
            ck_ctrl_o.add_word   = (idx32[1:0] == 2'd3) && (word_idx32 < words32 - 32'd2);
            ck_ctrl_o.check_word = (idx32[1:0] == 2'd3) && (word_idx32 == words32 - 32'd2);
            byte_count_d         = byte_count_q + CountW'(1);
            if (last) begin
              byte_count_d = '0;
              phase_d      = PH_HUNT;
            end
          end
        end
        default: begin
          phase_d     = PH_HUNT;
          bit_count_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      shift_q      <= '0;
      bit_count_q  <= '0;
      byte_count_q <= '0;
      bit_pos_q    <= '0;
      sync_pos_q   <= '0;
      words_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      shift_q      <= shift_d;
      bit_count_q  <= bit_count_d;
      byte_count_q <= byte_count_d;
      bit_pos_q    <= bit_pos_d;
      sync_pos_q   <= sync_pos_d;
      words_q      <= words_d;
    end
  end

  // Same address serves write (odd half) and read (even half)
  assign ram_addr_o     = byte_count_q[AddrW-1:0];
  assign ram_wdata_o    = {b[6], b[4], b[2], b[0]};
  assign emit_pending_o = (phase_q == PH_EVEN) && (bit_count_q == 5'd7);

  assign item_o.data_byte   = dbyte;
  assign item_o.byte_index  = idx32[ByteIndexW-1:0];
  assign item_o.last_byte   = last;
  assign item_o.checksum_ok = last && sum_match_i;
  assign item_o.sync_offset = sync32[SyncOffsetW-1:0];

  a_byte_phase_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ODD || phase_q == PH_EVEN) |-> bit_count_q < 5'd8)
    else $error("bit count out of byte range in data phase");

  a_even_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EVEN) |-> idx32 < bytes32)
    else $error("even half reads beyond block length");

endmodule

// ----- src/mfm_track_deframer_checksum_unit.sv -----
// ----------------------------------------------------------------------------
// mfm_track_deframer_checksum_unit
// Odd/even MFM track deframer with sync hunt, padding check and block sum.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | accepted when
//  bit_i   | in  | raw_bit, index_mark                            | valid && ready
//  byte_o  | out | data_byte, byte_index, last_byte, checksum_ok, | valid && ready
//          |     | sync_offset                                    |
//  cfg_i   | in  | reg_index, wdata                               | valid && ready
//
//  One raw bit is taken per cycle unless bit_i is held back; its state update
//  is done at the edge that accepts it, and a decoded byte lands in the output
//  register that edge, so the byte is on byte_o from the next cycle.
//  Reset clears all control state; the odd-half store needs no clearing pass.
//  A stalled byte_o holds bit_i back only on the bit that completes a decoded byte.
//  Configuration is always ready; the block length is latched at sync.
// ----------------------------------------------------------------------------
module mfm_track_deframer_checksum_unit
  import mtd_pkg::*;
#(
  parameter int MaxBlockBytes = 8192,
  parameter int PositionBits  = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mtd_stream_if.sink   bit_i,
  mtd_stream_if.source byte_o,
  mtd_stream_if.sink   cfg_i
);

  localparam int AddrW = $clog2(MaxBlockBytes);

  // Configuration registers
  logic [15:0] cfg_sync_q, cfg_pad_short_q;
  logic [31:0] cfg_pad_long_q;
  logic [11:0] cfg_words_q;
  cfg_req_t    cfg_req;

  assign cfg_req     = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sync_q      <= SyncPatternRst;
      cfg_pad_long_q  <= PadLongRst;
      cfg_pad_short_q <= PadShortRst;
      cfg_words_q     <= BlockWordsRst;
    end else if (cfg_i.valid) begin
      case (cfg_req.reg_index)
        CFG_SYNC_PATTERN: cfg_sync_q      <= cfg_req.wdata[15:0];
        CFG_PAD_LONG:     cfg_pad_long_q  <= cfg_req.wdata;
        CFG_PAD_SHORT:    cfg_pad_short_q <= cfg_req.wdata[15:0];
        CFG_BLOCK_WORDS:  cfg_words_q     <= cfg_req.wdata[11:0];
        default: ;
      endcase
    end
  end

  // Input handshake: refuse a bit only if it would complete a decoded byte
  // while the previous byte still sits unclaimed in the output register.
  logic      in_fire, emit_pending, emit;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, item;
  logic      out_stall;

  assign out_stall   = out_valid_q && !byte_o.ready;
  assign bit_i.ready = !(emit_pending && out_stall);
  assign in_fire     = bit_i.valid && bit_i.ready;

  // Odd-half store
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [3:0]       ram_wdata, ram_rdata;
  ck_ctrl_t         ck_ctrl;
  logic             sum_match;

  mtd_ram #(
    .Width (4),
    .Depth (MaxBlockBytes)
  ) u_odd_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  mtd_framer #(
    .MaxBlockBytes (MaxBlockBytes),
    .PositionBits  (PositionBits)
  ) u_framer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_fire_i       (in_fire),
    .in_item_i       (bit_i.data),
    .cfg_sync_i      (cfg_sync_q),
    .cfg_pad_long_i  (cfg_pad_long_q),
    .cfg_pad_short_i (cfg_pad_short_q),
    .cfg_words_i     (cfg_words_q),
    .ram_we_o        (ram_we),
    .ram_addr_o      (ram_addr),
    .ram_wdata_o     (ram_wdata),
    .ram_rdata_i     (ram_rdata),
    .ck_ctrl_o       (ck_ctrl),
    .sum_match_i     (sum_match),
    .emit_pending_o  (emit_pending),
    .emit_o          (emit),
    .item_o          (item)
  );

  mtd_checksum u_checksum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ck_ctrl),
    .sum_match_o (sum_match)
  );

  // Output register: load a fresh byte, drop the old one once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (byte_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= item;
    end
  end

  assign byte_o.valid = out_valid_q;
  assign byte_o.data  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !out_stall)
    else $error("decoded byte overwrote an unclaimed result");

  a_ok_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.checksum_ok) |-> out_q.last_byte)
    else $error("checksum verdict on a byte other than the last");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MFM track deframer and checksum unit. Builds
// raw bit streams of framed blocks, broken frames and noise, predicts every
// decoded byte in a cycle-free tracker and compares them as they leave.
// ----------------------------------------------------------------------------
module tb;
  import mtd_pkg::*;

  localparam int MaxBlockBytes = 8192;
  localparam int MaxWords      = MaxBlockBytes / 4;
  localparam int MinWords      = 3;
  localparam int ReportLimit   = 10;
  localparam int HoldOffCycles = 300;
  localparam int HoldOffAfter  = 5;

  // Block content styles
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  // Ways a frame can be broken
  localparam int FLAW_NONE      = 0;
  localparam int FLAW_PAD_LONG  = 1;
  localparam int FLAW_PAD_SHORT = 2;
  localparam int FLAW_CUT       = 3;

  localparam int NO_MARK = -1000;

  typedef struct {
    in_item_t item;
    bit       wait_drain;
  } raw_req_t;

  logic clk;
  logic rst_n;

  mtd_stream_if #(.T(in_item_t))  bit_if  ();
  mtd_stream_if #(.T(out_item_t)) byte_if ();
  mtd_stream_if #(.T(cfg_req_t))  cfg_if  ();

  mfm_track_deframer_checksum_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .bit_i  (bit_if),
    .byte_o (byte_if),
    .cfg_i  (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Tracker: register copy and frame state, advanced once per accepted bit
  // --------------------------------------------------------------------------
  logic [15:0]            cfg_sync;
  logic [31:0]            cfg_pad_long;
  logic [15:0]            cfg_pad_short;
  logic [11:0]            cfg_words;

  logic [31:0]            shreg;
  phase_e                 trk_phase;
  logic [4:0]             bit_cnt;
  int                     byte_cnt;
  int                     blk_bytes;
  logic [7:0]             odd_bits [MaxBlockBytes];
  logic [31:0]            blk_sum;
  logic [31:0]            word_asm;
  bit                     sum_ok;
  logic [SyncOffsetW-1:0] next_pos;
  logic [SyncOffsetW-1:0] sync_pos;

  out_item_t              byte_due [$];   // decoded bytes still to leave the block
  raw_req_t               raw_bits [$];   // bit requests waiting for the driver

  int  bits_queued;
  int  bits_taken;
  int  results_seen;
  int  fault_count;
  int  mark_rate;       // on average one random index mark per this many bits, 0 for none
  int  frame_bit;
  int  frame_cut;
  int  frame_mark;
  bit  frame_drain;
  logic bit_taken;

  function automatic int clamp_words(logic [11:0] v);
    int w;
    w = v;
    if (w < MinWords) w = MinWords;
    if (w > MaxWords) w = MaxWords;
    return w;
  endfunction

  function automatic void reset_tracker();
    cfg_sync      = SyncPatternRst;
    cfg_pad_long  = PadLongRst;
    cfg_pad_short = PadShortRst;
    cfg_words     = BlockWordsRst;
    shreg         = '0;
    trk_phase     = PH_HUNT;
    bit_cnt       = '0;
    byte_cnt      = 0;
    blk_bytes     = 0;
    blk_sum       = '0;
    word_asm      = '0;
    sum_ok        = 1'b0;
    next_pos      = '0;
    sync_pos      = '0;
  endfunction

  // Advance the tracker by one raw bit and queue the byte it completes, if any
  function automatic void track_clock_in(in_item_t rq);
    logic [SyncOffsetW-1:0] pos;
    logic [7:0]             dec;
    int                     nwords;
    bit                     last;
    out_item_t              res;
    pos      = rq.index_mark ? '0 : next_pos;
    next_pos = pos + 1'b1;
    shreg    = {shreg[30:0], rq.raw_bit};
    case (trk_phase)
      PH_HUNT: begin
        if (shreg[15:0] == cfg_sync) begin
          // The sync began fifteen bits back; wrap below the index if need be
          sync_pos  = pos - SyncOffsetW'(15);
          blk_bytes = clamp_words(cfg_words) * 4;
          trk_phase = PH_PADL;
          bit_cnt   = '0;
        end
      end
      PH_PADL: begin
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt == 5'd0) begin
          if (shreg == cfg_pad_long) trk_phase = PH_PADS;
          else trk_phase = PH_HUNT;
        end
      end
      PH_PADS: begin
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt == 5'd16) begin
          bit_cnt  = '0;
          byte_cnt = 0;
          if (shreg[15:0] == cfg_pad_short) begin
            trk_phase = PH_ODD;
            blk_sum   = '0;
            word_asm  = '0;
            sum_ok    = 1'b0;
          end else begin
            trk_phase = PH_HUNT;
          end
        end
      end
      PH_ODD: begin
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt == 5'd8) begin
          bit_cnt = '0;
          odd_bits[byte_cnt] = shreg[7:0] & 8'h55;
          byte_cnt++;
          if (byte_cnt >= blk_bytes) begin
            byte_cnt  = 0;
            trk_phase = PH_EVEN;
          end
        end
      end
      PH_EVEN: begin
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt == 5'd8) begin
          bit_cnt  = '0;
          dec      = {odd_bits[byte_cnt][6:0], 1'b0} | (shreg[7:0] & 8'h55);
          word_asm = {word_asm[23:0], dec};
          nwords   = blk_bytes / 4;
          if (byte_cnt % 4 == 3) begin
            if (byte_cnt / 4 < nwords - 2) blk_sum = blk_sum + word_asm;
            else if (byte_cnt / 4 == nwords - 2) sum_ok = (blk_sum == word_asm);
          end
          last            = (byte_cnt + 1 >= blk_bytes);
          res.data_byte   = dec;
          res.byte_index  = byte_cnt[ByteIndexW-1:0];
          res.last_byte   = last;
          res.checksum_ok = last && sum_ok;
          res.sync_offset = sync_pos;
          byte_due.push_back(res);
          byte_cnt++;
          if (last) begin
            trk_phase = PH_HUNT;
            byte_cnt  = 0;
          end
        end
      end
      default: begin
        trk_phase = PH_HUNT;
        bit_cnt   = '0;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stream building
  // --------------------------------------------------------------------------
  function automatic void push_bit(logic b, logic m);
    raw_req_t rq;
    rq.item.raw_bit    = b;
    rq.item.index_mark = m || (mark_rate != 0 && $urandom_range(mark_rate - 1, 0) == 0);
    rq.wait_drain      = frame_drain;
    frame_drain        = 1'b0;
    raw_bits.push_back(rq);
    bits_queued++;
  endfunction

  function automatic void push_noise(int n);
    for (int k = 0; k < n; k++) push_bit($urandom_range(1, 0), 1'b0);
  endfunction

  // Emit the low n bits of v, MSB first, honouring the frame's cut and mark
  function automatic void emit(logic [31:0] v, int n);
    for (int k = n - 1; k >= 0; k--) begin
      if (frame_bit < frame_cut) push_bit(v[k], frame_bit == frame_mark);
      frame_bit++;
    end
  endfunction

  // One frame under the current registers. Bit 0 of mark_at is the first
  // sync bit; a short preamble of the inverted sync goes ahead of it so that
  // trailing noise is less likely to complete the sync early.
  function automatic void add_frame(int fill, bit bad_sum, int flaw, int mark_at, bit drain);
    logic [31:0] words [$];
    logic [31:0] sum;
    logic [31:0] w;
    logic [7:0]  d;
    int          nwords;
    int          nbytes;
    frame_drain = drain;
    frame_mark  = mark_at;
    frame_cut   = 1 << 30;
    frame_bit   = -16;
    emit({16'h0, ~cfg_sync}, 16);
    emit({16'h0, cfg_sync}, 16);
    if (flaw == FLAW_PAD_LONG) begin
      emit(cfg_pad_long ^ (32'd1 << $urandom_range(31, 0)), 32);
      return;
    end
    emit(cfg_pad_long, 32);
    if (flaw == FLAW_PAD_SHORT) begin
      emit({16'h0, cfg_pad_short ^ (16'd1 << $urandom_range(15, 0))}, 16);
      return;
    end
    emit({16'h0, cfg_pad_short}, 16);

    nwords = clamp_words(cfg_words);
    nbytes = nwords * 4;
    sum    = '0;
    for (int i = 0; i < nwords; i++) begin
      case (fill)
        FILL_ZERO: w = '0;
        FILL_ONES: w = '1;
        default:   w = $urandom;
      endcase
      if (i < nwords - 2) sum = sum + w;
      else if (i == nwords - 2) w = sum ^ (bad_sum ? 32'd1 << $urandom_range(31, 0) : 32'd0);
      words.push_back(w);
    end
    // A cut frame stops somewhere inside the odd or even half
    if (flaw == FLAW_CUT) frame_cut = 64 + $urandom_range(nbytes * 16 - 1, 1);
    for (int i = 0; i < nbytes; i++) begin
      d = words[i / 4] >> (24 - 8 * (i % 4));
      emit(((d >> 1) & 8'h55) | ($urandom & 32'hAA), 8);
    end
    for (int i = 0; i < nbytes; i++) begin
      d = words[i / 4] >> (24 - 8 * (i % 4));
      emit((d & 8'h55) | ($urandom & 32'hAA), 8);
    end
  endfunction

  // Mostly well-formed frames with random content, the rest broken or noise
  function automatic void random_traffic(int budget);
    int start;
    int pick;
    int fill;
    start = bits_queued;
    add_frame(FILL_RANDOM, $urandom_range(2, 0) == 0, FLAW_NONE, NO_MARK, 1'b0);
    while (bits_queued - start < budget) begin
      pick = $urandom_range(99, 0);
      fill = ($urandom_range(9, 0) == 0) ? $urandom_range(FILL_ONES, FILL_ZERO) : FILL_RANDOM;
      if (pick < 65)
        add_frame(fill, $urandom_range(2, 0) == 0, FLAW_NONE, NO_MARK,
                  $urandom_range(5, 0) == 0);
      else if (pick < 72) add_frame(fill, 1'b0, FLAW_PAD_LONG, NO_MARK, 1'b0);
      else if (pick < 79) add_frame(fill, 1'b0, FLAW_PAD_SHORT, NO_MARK, 1'b0);
      else if (pick < 86) add_frame(fill, 1'b0, FLAW_CUT, NO_MARK, 1'b0);
      else push_noise($urandom_range(40, 1));
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (fault_count < ReportLimit)
        $display("byte %0d: %s expected %0h, got %0h", results_seen, name, want, got);
      fault_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bit driver: bursts of random length with random gaps. A request flagged
  // to wait for drain is held back until every predicted byte has left.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst_n && (!bit_if.valid || bit_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        bit_if.valid <= 1'b0;
      end else if (raw_bits.size() == 0 ||
                   (raw_bits[0].wait_drain && byte_due.size() != 0)) begin
        bit_if.valid <= 1'b0;
      end else begin
        bit_if.valid <= 1'b1;
        bit_if.data  <= raw_bits[0].item;
        raw_bits.pop_front();
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(48, 1);
          // Half the bursts run straight into the next one
          gap_left = $urandom_range(1, 0) ? 0 : $urandom_range(5, 1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte receiver: a stall mode that changes every so often, plus one long
  // hold-off once some bytes have come, so that the output fills and the
  // bit channel gets stalled while the driver keeps offering
  // --------------------------------------------------------------------------
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int stall_tick = 0;
  int stall_mode = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        byte_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldOffAfter) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles;
        byte_if.ready <= 1'b0;
      end else begin
        stall_tick++;
        if (stall_tick % 97 == 0) stall_mode = $urandom_range(3, 0);
        case (stall_mode)
          0:       byte_if.ready <= 1'b1;
          1:       byte_if.ready <= $urandom_range(1, 0);
          2:       byte_if.ready <= (stall_tick % 4 == 0);
          default: byte_if.ready <= ($urandom_range(7, 0) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the leaving byte against the oldest prediction first, then
  // advance the tracker with the bit taken at this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : byte_monitor
    out_item_t want;
    bit_taken <= rst_n && bit_if.valid && bit_if.ready;
    if (rst_n) begin
      if (byte_if.valid && byte_if.ready) begin
        results_seen++;
        if (byte_due.size() == 0) begin
          if (fault_count < ReportLimit)
            $display("byte %0d: unexpected, got %0h", results_seen, byte_if.data);
          fault_count++;
        end else begin
          want = byte_due.pop_front();
          check_field("data_byte", want.data_byte, byte_if.data.data_byte);
          check_field("byte_index", want.byte_index, byte_if.data.byte_index);
          check_field("last_byte", want.last_byte, byte_if.data.last_byte);
          check_field("checksum_ok", want.checksum_ok, byte_if.data.checksum_ok);
          check_field("sync_offset", want.sync_offset, byte_if.data.sync_offset);
        end
      end
      if (bit_if.valid && bit_if.ready) begin
        track_clock_in(bit_if.data);
        bits_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writes, only while the deframer is hunting with nothing pending
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [3:0] idx, logic [31:0] wd);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_index: idx, wdata: wd};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_SYNC_PATTERN: cfg_sync      = wd[15:0];
      CFG_PAD_LONG:     cfg_pad_long  = wd;
      CFG_PAD_SHORT:    cfg_pad_short = wd[15:0];
      CFG_BLOCK_WORDS:  cfg_words     = wd[11:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait for every request to go in and every byte to come out; if a cut
  // frame left the deframer mid-block, feed noise until it is hunting again
  task automatic settle();
    forever begin
      @(negedge clk);
      if (bits_queued == bits_taken && byte_due.size() == 0) begin
        if (trk_phase == PH_HUNT) break;
        push_noise(16);
      end
    end
    repeat (4) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    bit_if.valid  = 1'b0;
    bit_if.data   = '0;
    byte_if.ready = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    bits_queued   = 0;
    bits_taken    = 0;
    results_seen  = 0;
    fault_count   = 0;
    mark_rate     = 0;
    frame_drain   = 1'b0;
    bit_taken     = 1'b0;
    reset_tracker();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset patterns with the shortest block
    write_reg(CFG_BLOCK_WORDS, 32'd3);
    end_writes();
    add_frame(FILL_ZERO, 1'b0, FLAW_NONE, 15, 1'b0);          // sync offset wraps
    add_frame(FILL_RANDOM, 1'b1, FLAW_NONE, 200, 1'b0);       // bad sum, index in block
    add_frame(FILL_RANDOM, 1'b0, FLAW_PAD_LONG, NO_MARK, 1'b0);
    add_frame(FILL_RANDOM, 1'b0, FLAW_PAD_SHORT, NO_MARK, 1'b0);
    add_frame(FILL_RANDOM, 1'b0, FLAW_CUT, NO_MARK, 1'b0);
    push_noise(40);
    settle();

    // All-zero sync and short padding, long padding all ones; length clamps up
    mark_rate = 200;
    write_reg(CFG_SYNC_PATTERN, $urandom & 32'hFFFF_0000);
    write_reg(CFG_PAD_LONG, 32'hFFFF_FFFF);
    write_reg(CFG_PAD_SHORT, $urandom & 32'hFFFF_0000);
    write_reg(CFG_BLOCK_WORDS, 32'd0);
    end_writes();
    random_traffic(0);
    settle();

    // The opposite extremes
    write_reg(CFG_SYNC_PATTERN, 32'h0000_FFFF);
    write_reg(CFG_PAD_LONG, 32'h0000_0000);
    write_reg(CFG_PAD_SHORT, 32'hFFFF_FFFF);
    write_reg(CFG_BLOCK_WORDS, 32'd2);
    end_writes();
    random_traffic(0);
    settle();

    // Random patterns; a frame that waits for the output to drain
    write_reg(CFG_SYNC_PATTERN, $urandom);
    write_reg(CFG_PAD_LONG, $urandom);
    write_reg(CFG_PAD_SHORT, $urandom);
    write_reg(CFG_BLOCK_WORDS, $urandom_range(6, 3));
    end_writes();
    add_frame(FILL_RANDOM, 1'b0, FLAW_NONE, NO_MARK, 1'b1);
    push_noise(20);
    settle();

    repeat (20) @(negedge clk);
    if (byte_due.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Guard against a hang: well beyond the slowest legal run
  initial begin
    #30ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mtd_pkg.sv
src/mtd_stream_if.sv
src/mtd_ram.sv
src/mtd_checksum.sv
src/mtd_framer.sv
src/mfm_track_deframer_checksum_unit.sv
test/tb.sv
